// ----- src/lkvc_pkg.sv -----
package lkvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 5;
    localparam int FILL_W    = $clog2(ENTRIES + 1);
    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_HIT,
        SHIFT_VALID,
        SHIFT_ALL
    } lkvc_shift_t;

    typedef struct packed {
        logic                      action;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } lkvc_req_t;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] read_value;
        logic                      evicted;
        logic signed [KEY_W-1:0]   evicted_key;
    } lkvc_rsp_t;

    // entry handed from a more recent cell to the next older one
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } lkvc_entry_t;

    // lookup results gathered from the old end toward the head
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [VALUE_W-1:0] hit_value;
        logic [KEY_W-1:0]   tail_key;
    } lkvc_back_t;

    typedef struct packed {
        logic             compare;
        logic [KEY_W-1:0] cmp_key;
        logic             update;
        lkvc_shift_t      mode;
    } lkvc_ctrl_t;

endpackage

// ----- src/lkvc_cell.sv -----
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lkvc_ctrl_t  ctrl,
    input  lkvc_entry_t prev,
    output lkvc_entry_t here,
    input  lkvc_back_t  next,
    output lkvc_back_t  back
);

    logic               valid_reg;
    logic               match_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               shift;

    assign here.valid = valid_reg;
    assign here.key   = key_reg;
    assign here.value = value_reg;

    // keys are unique among valid cells, so at most one cell matches
    assign back.valid     = valid_reg;
    assign back.hit       = match_reg || next.hit;
    assign back.hit_value = match_reg ? value_reg : next.hit_value;
    assign back.tail_key  = (valid_reg && !next.valid) ? key_reg : next.tail_key;

    always_comb
    begin
        case (ctrl.mode)
            SHIFT_HIT:   shift = back.hit;
            SHIFT_VALID: shift = valid_reg;
            SHIFT_ALL:   shift = 1'b1;
            default:     shift = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.compare)
            begin
                match_reg <= valid_reg && (key_reg == ctrl.cmp_key);
            end
            if (ctrl.update && shift)
            begin
                valid_reg <= prev.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update && shift)
        begin
            key_reg   <= prev.key;
            value_reg <= prev.value;
        end
    end

endmodule

// ----- src/lru_key_value_cache_core.sv -----
// Fully associative key-value cache with least-recently-used replacement.
// Entries sit in a row of cells ordered by recency: the head cell holds the
// most recent entry, valid entries are packed from the head.
// Command channel: req is taken at a clock edge where start is high and busy
// is low; action 0 is a get, 1 is a put. The key is compared in every cell
// at that edge. In the next cycle the cells shift toward the old end up to
// the hit (on an insert: valid cells if full, else all), the head takes the
// accessed entry, and the result is registered; a get miss moves no cell.
// Result: rsp is shown for exactly one cycle with done high, registered as
// the shift ends. The receiver cannot stall; it must take each word.
// Each access is a compare step followed by a shift step, during which busy
// is high; a new start may be accepted in the cycle done is high.
// Configuration: cfg_data writes capacity when cfg_valid is high (cfg_ready
// is always high); write it only while no access is in flight.
// Reset: all cells invalid, fill zero, capacity 16. No clearing pass.
module lru_key_value_cache_core
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lkvc_req_t        req,
    output logic             done,
    output lkvc_rsp_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    typedef enum logic {
        IDLE,
        UPDATE
    } state_t;

    state_t              state_reg;
    logic                done_reg;
    lkvc_rsp_t           rsp_reg;
    lkvc_rsp_t           rsp_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [CAP_W-1:0]    capacity_reg;
    logic                action_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic                take;
    logic [FILL_W-1:0]   eff_cap;
    logic                full;
    logic                hit;
    lkvc_ctrl_t          ctrl;
    lkvc_entry_t         fwd [ENTRIES+1];
    lkvc_back_t          bwd [ENTRIES+1];

    assign busy      = (state_reg == UPDATE);
    assign take      = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = FILL_W'(1);
        else if (int'(capacity_reg) > ENTRIES)
            eff_cap = FILL_W'(ENTRIES);
        else
            eff_cap = FILL_W'(capacity_reg);
    end

    assign hit  = bwd[0].hit;
    assign full = (fill_reg >= eff_cap) && (fill_reg != '0);

    // head takes the accessed key on a hit or a put; a put also brings the new value
    assign fwd[0].valid = 1'b1;
    assign fwd[0].key   = key_reg;
    assign fwd[0].value = action_reg ? value_reg : bwd[0].hit_value;
    assign bwd[ENTRIES] = '0;

    always_comb
    begin
        ctrl.compare = take;
        ctrl.cmp_key = req.key;
        ctrl.update  = (state_reg == UPDATE);
        if (hit)
            ctrl.mode = SHIFT_HIT;
        else if (!action_reg)
            ctrl.mode = SHIFT_NONE;
        else if (full)
            ctrl.mode = SHIFT_VALID;
        else
            ctrl.mode = SHIFT_ALL;
    end

    always_comb
    begin
        rsp_next.found       = hit;
        rsp_next.read_value  = (!action_reg && hit) ? bwd[0].hit_value : '0;
        rsp_next.evicted     = action_reg && !hit && full;
        rsp_next.evicted_key = (action_reg && !hit && full) ? bwd[0].tail_key : '0;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (fwd[i]),
            .here  (fwd[i+1]),
            .next  (bwd[i+1]),
            .back  (bwd[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            done_reg     <= 1'b0;
            fill_reg     <= '0;
            capacity_reg <= CAP_W'(CAP_RESET);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            unique case (state_reg)
                IDLE:
                begin
                    done_reg <= 1'b0;
                    if (take)
                    begin
                        state_reg <= UPDATE;
                    end
                end
                UPDATE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= IDLE;
                    // an insert into a full store evicts one, so the fill holds
                    if (action_reg && !hit && !full)
                    begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= req.action;
            key_reg    <= req.key;
            value_reg  <= req.value;
        end
        if (state_reg == UPDATE)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import lkvc_pkg::*;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;
    localparam int   WATCHDOG_CYCLES = 400;
    localparam int   SETTLE_CYCLES   = 8;
    localparam int   POOL_SIZE       = 24;
    localparam int   PHASE_ITEMS     = 112;

    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hffff_ffff;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    lkvc_req_t        req = '0;
    logic             done;
    lkvc_rsp_t        rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    // shadow of the cache contents and recency order
    logic [KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [VALUE_W-1:0] shadow_value [ENTRIES];
    bit                 shadow_valid [ENTRIES];
    int unsigned        shadow_rank  [ENTRIES];
    int unsigned        shadow_fill = 0;
    logic [CAP_W-1:0]   shadow_capacity = CAP_W'(CAP_RESET);

    lkvc_rsp_t          pending_rsp [$];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    bit                 no_idle = 1'b0;
    int                 errors = 0;
    int                 idle_cycles = 0;

    lru_key_value_cache_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned usable_entries(input logic [CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > ENTRIES)
            return ENTRIES;
        return int'(cap);
    endfunction

    // apply one access to the shadow and return the word it must produce
    function automatic lkvc_rsp_t cache_access(input lkvc_req_t item);
        lkvc_rsp_t   word;
        int          hit_idx;
        int          free_idx;
        int          lru_idx;
        word     = '0;
        hit_idx  = -1;
        free_idx = -1;
        lru_idx  = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_idx < 0 && shadow_valid[i] && shadow_key[i] == item.key)
                hit_idx = i;
        if (hit_idx >= 0)
        begin
            word.found = 1'b1;
            if (item.action == ACT_GET)
                word.read_value = shadow_value[hit_idx];
            else
                shadow_value[hit_idx] = item.value;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && shadow_rank[i] < shadow_rank[hit_idx])
                    shadow_rank[i]++;
            shadow_rank[hit_idx] = 0;
        end
        else if (item.action == ACT_PUT)
        begin
            if (shadow_fill >= usable_entries(shadow_capacity) && shadow_fill > 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i] &&
                        (lru_idx < 0 || shadow_rank[i] > shadow_rank[lru_idx]))
                        lru_idx = i;
                word.evicted     = 1'b1;
                word.evicted_key = shadow_key[lru_idx];
                shadow_valid[lru_idx] = 1'b0;
                shadow_rank[lru_idx]  = 0;
                shadow_fill--;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (free_idx < 0 && !shadow_valid[i])
                    free_idx = i;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_rank[i]++;
            shadow_key[free_idx]   = item.key;
            shadow_value[free_idx] = item.value;
            shadow_valid[free_idx] = 1'b1;
            shadow_rank[free_idx]  = 0;
            shadow_fill++;
        end
        return word;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // call at a rising edge; returns at a rising edge
    task automatic send_access(input logic act, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v);
        lkvc_req_t item;
        int        gap;
        item.action = act;
        item.key    = k;
        item.value  = v;
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
        pending_rsp.push_back(cache_access(item));
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_capacity = cap;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic test_capacity_low();
        write_capacity(1);
        send_access(ACT_GET, 32'h0000_0011, $urandom);   // empty store
        send_access(ACT_PUT, 32'h0000_0011, 32'h0000_1111);
        send_access(ACT_PUT, 32'h0000_0022, 32'h0000_2222);
        send_access(ACT_GET, 32'h0000_0011, $urandom);
        send_access(ACT_GET, 32'h0000_0022, $urandom);
        // zero acts as one
        write_capacity(0);
        send_access(ACT_PUT, 32'h0000_0033, 32'h0000_3333);
        send_access(ACT_GET, 32'h0000_0033, $urandom);
    endtask

    task automatic test_field_extremes();
        // above the entry count clamps to the full store
        write_capacity(31);
        send_access(ACT_PUT, KEY_MIN, KEY_MAX);
        send_access(ACT_PUT, KEY_MAX, KEY_MIN);
        send_access(ACT_PUT, '0, KEY_ONES);
        send_access(ACT_PUT, KEY_ONES, '0);
        send_access(ACT_GET, KEY_MIN, KEY_ONES);
        send_access(ACT_GET, KEY_ONES, $urandom);
        send_access(ACT_PUT, KEY_MAX, 32'd123);
        send_access(ACT_GET, KEY_MAX, '0);
        send_access(ACT_GET, '0, $urandom);
        send_access(ACT_GET, 32'd5, $urandom);
    endtask

    task automatic test_capacity_lowered();
        // fill stays above the new capacity; each insert evicts one
        write_capacity(2);
        send_access(ACT_PUT, 32'h0000_0044, 32'h0000_4444);
        send_access(ACT_PUT, 32'h0000_0055, 32'h0000_5555);
        send_access(ACT_GET, 32'h0000_0044, $urandom);
    endtask

    task automatic test_random_traffic();
        int               caps [8];
        int               span;
        logic [KEY_W-1:0] k;
        caps = '{3, 1, 8, 0, 12, 16, 31, 0};
        caps[7] = $urandom_range(0, 31);
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(CAP_W'(caps[p]));
            for (int j = 0; j < POOL_SIZE; j++)
                key_pool[j] = $urandom;
            span = usable_entries(CAP_W'(caps[p])) + $urandom_range(1, 6);
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, span - 1)];
                send_access(1'($urandom_range(0, 1)), k, $urandom);
            end
        end
    endtask

    always @(posedge clk)
    begin
        lkvc_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result word with none expected: actual %h", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("found", 32'(want.found), 32'(rsp.found));
                check_field("read_value", want.read_value, rsp.read_value);
                check_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
                check_field("evicted_key", want.evicted_key, rsp.evicted_key);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("lru_key_value_cache_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_capacity_low();
        test_field_extremes();
        test_capacity_lowered();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("lru_key_value_cache_core regression: pass");
        else
            $display("lru_key_value_cache_core regression: fail");
        $finish;
    end

endmodule
